>>> src/pcpm_pkg.sv
// ----------------------------------------------------------------------------
// pcpm_pkg: shared types and constants
// Item formats, command and register codes, queue sizing and the byte
// popcount used by the code comparison block.
// ----------------------------------------------------------------------------
package pcpm_pkg;

  // Input item commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_REF  = 1'b1
  } cmd_t;

  // Combine modes
  localparam logic MODE_XOR = 1'b0;
  localparam logic MODE_AND = 1'b1;

  // Configuration register indexes
  localparam int          CFG_IDX_W      = 2;
  localparam int          CFG_DATA_W     = 16;
  localparam logic [1:0]  REG_MODE       = 2'd0;
  localparam logic [1:0]  REG_CODE_BYTES = 2'd1;
  localparam logic [1:0]  REG_REFS_ROW   = 2'd2;

  // Field widths
  localparam int CODE_BYTES_W = 7;
  localparam int REFS_W       = 16;
  localparam int COUNT_W      = 10;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Input item
  typedef struct packed {
    logic       command;
    logic [7:0] data;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               row_end;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;     // last byte of a reference code
    logic       row_end;  // last reference of the row (valid with last)
  } job_t;

  // Ones in one byte
  function automatic logic [3:0] byte_popcount(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage

>>> src/pairwise_code_popcount_matrix_top.sv
// ----------------------------------------------------------------------------
// pairwise_code_popcount_matrix_top: binary code popcount comparison
// Compares reference codes byte by byte against a stored query code and
// gives the Hamming distance or intersection size of each reference.
//
// Input channel (in_valid/in_stall/in_data): one code byte per item. A load
// item writes the next query byte and restarts the row; a reference item
// streams the next reference byte. An item is taken at each edge where
// in_valid is high and in_stall is low.
// Result channel (out_valid/out_stall/out_data): one item after the last
// byte of each reference code, with the count and a row-end flag.
// Configuration (cfg_we/cfg_index/cfg_wdata): mode, code_bytes, refs_per_row,
// which the user must write only while the block is idle; it is not enforced.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single store port and one byte popcount plus add per cycle. From the
// last reference byte to out_valid an item passes the queue, the store read
// and the result register. A four-entry queue separates intake from the back
// end, so when the receiver stalls, input keeps flowing until that queue fills.
// Reset clears positions, counts, queue and valids; the query store holds
// no value until it is loaded.
// ----------------------------------------------------------------------------
module pairwise_code_popcount_matrix_top #(
  parameter int MAX_CODE_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pcpm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pcpm_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [pcpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
  localparam int QW = PW + $bits(pcpm_pkg::job_t);

  logic                              mode_r, mode_nxt;
  logic [pcpm_pkg::CODE_BYTES_W-1:0] code_bytes_r, code_bytes_nxt;
  logic [pcpm_pkg::REFS_W-1:0]       refs_r, refs_nxt;

  logic           push, pop, q_full, q_empty;
  pcpm_pkg::job_t push_job, pop_job;
  logic [PW-1:0]  push_pos, pop_pos;
  logic [QW-1:0]  q_in, q_out;

  // Configuration registers
  always_comb begin
    mode_nxt       = mode_r;
    code_bytes_nxt = code_bytes_r;
    refs_nxt       = refs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pcpm_pkg::REG_MODE:       mode_nxt       = cfg_wdata[0];
        pcpm_pkg::REG_CODE_BYTES: code_bytes_nxt = cfg_wdata[pcpm_pkg::CODE_BYTES_W-1:0];
        pcpm_pkg::REG_REFS_ROW:   refs_nxt       = cfg_wdata[pcpm_pkg::REFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= pcpm_pkg::MODE_XOR;
      code_bytes_r <= pcpm_pkg::CODE_BYTES_W'(1);
      refs_r       <= pcpm_pkg::REFS_W'(1);
    end else begin
      mode_r       <= mode_nxt;
      code_bytes_r <= code_bytes_nxt;
      refs_r       <= refs_nxt;
    end
  end

  pcpm_front #(
    .MAX_CODE_BYTES(MAX_CODE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .code_bytes  (code_bytes_r),
    .refs_per_row(refs_r),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job),
    .push_pos    (push_pos)
  );

  // Queue entry: store address and tagged item
  assign q_in              = {push_pos, push_job};
  assign {pop_pos, pop_job} = q_out;

  pcpm_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(q_in),
    .pop      (pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  pcpm_back #(
    .MAX_CODE_BYTES(MAX_CODE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .q_empty  (q_empty),
    .pop      (pop),
    .pop_job  (pop_job),
    .pop_pos  (pop_pos),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> src/pcpm_front.sv
// ----------------------------------------------------------------------------
// pcpm_front: item intake and classification
// Tracks load position, reference position and column count, and tags each
// item with its store address, last-byte and row-end flags.
// ----------------------------------------------------------------------------
module pcpm_front #(
  parameter int MAX_CODE_BYTES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcpm_pkg::in_item_t                 in_data,
  input  logic [pcpm_pkg::CODE_BYTES_W-1:0]  code_bytes,
  input  logic [pcpm_pkg::REFS_W-1:0]        refs_per_row,
  input  logic                               q_full,
  output logic                               push,
  output pcpm_pkg::job_t                     push_job,
  output logic [((MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1)-1:0] push_pos
);

  localparam int PW = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;
  localparam int LW = $clog2(MAX_CODE_BYTES + 1);
  localparam int CW = (LW > pcpm_pkg::CODE_BYTES_W) ? LW : pcpm_pkg::CODE_BYTES_W;

  logic [PW-1:0]               load_pos_r, load_pos_nxt;
  logic [PW-1:0]               ref_pos_r, ref_pos_nxt;
  logic [pcpm_pkg::REFS_W-1:0] col_r, col_nxt;

  logic [CW-1:0]               cb_ext, len;
  logic [pcpm_pkg::REFS_W-1:0] row;
  logic [PW-1:0]               load_use, ref_use;
  logic [CW-1:0]               load_inc, ref_inc;
  logic                        load_last, ref_last;
  logic [pcpm_pkg::REFS_W-1:0] col_use;
  logic [pcpm_pkg::REFS_W:0]   col_inc;
  logic                        row_end;
  logic                        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  // Effective code and row lengths
  always_comb begin
    cb_ext = CW'(code_bytes);
    if (cb_ext == '0) begin
      len = CW'(1);
    end else if (cb_ext > CW'(MAX_CODE_BYTES)) begin
      len = CW'(MAX_CODE_BYTES);
    end else begin
      len = cb_ext;
    end
    row = (refs_per_row == '0) ? pcpm_pkg::REFS_W'(1) : refs_per_row;
  end

  // Positions, restarted when out of range
  always_comb begin
    load_use  = (CW'(load_pos_r) >= len) ? '0 : load_pos_r;
    load_inc  = CW'(load_use) + CW'(1);
    load_last = (load_inc >= len);
    ref_use   = (CW'(ref_pos_r) >= len) ? '0 : ref_pos_r;
    ref_inc   = CW'(ref_use) + CW'(1);
    ref_last  = (ref_inc >= len);
    col_use   = (col_r >= row) ? '0 : col_r;
    col_inc   = {1'b0, col_use} + (pcpm_pkg::REFS_W + 1)'(1);
    row_end   = (col_inc == {1'b0, row});
  end

  // Next state and tagged item
  always_comb begin
    load_pos_nxt = load_pos_r;
    ref_pos_nxt  = ref_pos_r;
    col_nxt      = col_r;
    push_job.cmd     = pcpm_pkg::cmd_t'(in_data.command);
    push_job.data    = in_data.data;
    push_job.last    = 1'b0;
    push_job.row_end = 1'b0;
    push_pos         = ref_use;
    if (in_data.command == pcpm_pkg::CMD_LOAD) begin
      push_pos = load_use;
      if (accept) begin
        load_pos_nxt = load_last ? '0 : load_inc[PW-1:0];
        ref_pos_nxt  = '0;
        col_nxt      = '0;
      end
    end else begin
      push_job.last    = ref_last;
      push_job.row_end = row_end;
      if (accept) begin
        ref_pos_nxt = ref_last ? '0 : ref_inc[PW-1:0];
        if (ref_last) begin
          col_nxt = row_end ? '0 : col_inc[pcpm_pkg::REFS_W-1:0];
        end else begin
          col_nxt = col_use;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      ref_pos_r  <= '0;
      col_r      <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
      ref_pos_r  <= ref_pos_nxt;
      col_r      <= col_nxt;
    end
  end

endmodule

>>> src/pcpm_queue.sv
// ----------------------------------------------------------------------------
// pcpm_queue: short item queue
// Small register queue that decouples the front stall from the back stall.
// ----------------------------------------------------------------------------
module pcpm_queue #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]             slot_r [pcpm_pkg::Q_DEPTH];
  logic [pcpm_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pcpm_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pcpm_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == pcpm_pkg::Q_CNT_W'(pcpm_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/pcpm_back.sv
// ----------------------------------------------------------------------------
// pcpm_back: query store, combine and accumulate
// Writes load bytes into the query store, reads the matching byte for each
// reference byte, accumulates the popcount and holds the result register.
// ----------------------------------------------------------------------------
module pcpm_back #(
  parameter int MAX_CODE_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mode,
  input  logic                 q_empty,
  output logic                 pop,
  input  pcpm_pkg::job_t       pop_job,
  input  logic [((MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1)-1:0] pop_pos,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcpm_pkg::out_item_t  out_data
);

  localparam int AW = pcpm_pkg::COUNT_W;

  logic [7:0]          store [MAX_CODE_BYTES];
  logic [7:0]          rd_r;
  logic                a_valid_r, a_valid_nxt;
  pcpm_pkg::job_t      a_job_r;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  pcpm_pkg::out_item_t out_r;

  logic [7:0]          comb;
  logic [AW:0]         sum;
  logic [AW-1:0]       sat;
  logic                is_ref, emit, out_free, adv_b;

  // Combine with the query byte and accumulate with saturation
  always_comb begin
    comb = (mode == pcpm_pkg::MODE_AND) ? (rd_r & a_job_r.data) : (rd_r ^ a_job_r.data);
    sum  = {1'b0, acc_r} + (AW + 1)'(pcpm_pkg::byte_popcount(comb));
    sat  = sum[AW] ? '1 : sum[AW-1:0];
  end

  // Stage handshakes
  assign is_ref   = (a_job_r.cmd == pcpm_pkg::CMD_REF);
  assign emit     = a_valid_r && is_ref && a_job_r.last;
  assign out_free = !out_valid_r || !out_stall;
  assign adv_b    = a_valid_r && (!emit || out_free);
  assign pop      = !q_empty && (!a_valid_r || adv_b);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (pop) begin
      a_valid_nxt = 1'b1;
    end else if (adv_b) begin
      a_valid_nxt = 1'b0;
    end
    acc_nxt = acc_r;
    if (adv_b) begin
      acc_nxt = (!is_ref || a_job_r.last) ? '0 : sat;
    end
    out_valid_nxt = out_valid_r;
    if (emit && adv_b) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Query store: load writes, reference reads with registered data
  always_ff @(posedge clk) begin
    if (pop) begin
      if (pop_job.cmd == pcpm_pkg::CMD_LOAD) begin
        store[pop_pos] <= pop_job.data;
      end else begin
        rd_r <= store[pop_pos];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      a_job_r <= pop_job;
    end
    if (emit && adv_b) begin
      out_r.count   <= sat;
      out_r.row_end <= a_job_r.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: code popcount comparison block
// Streams query loads and reference code bytes through the block under
// several mode, code length and row length settings, predicts every count
// and row-end flag, and checks each result in order. Both handshakes idle at
// random, and one stretch holds the result side off until the input backs up.
// ----------------------------------------------------------------------------
module testbench;

  // Predicts counts and row ends from accepted items
  class popcount_predictor;
    logic [7:0]  query[64];
    bit          loaded[64];
    int unsigned load_pos, ref_pos, acc, col;
    logic        mode;
    logic [6:0]  code_bytes;
    logic [15:0] refs_row;
    pcpm_pkg::out_item_t counts_due[$];
    int          errors, results, row_ends, loads, refs;

    function new();
      mode       = pcpm_pkg::MODE_XOR;
      code_bytes = 7'd1;
      refs_row   = 16'd1;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function int unsigned eff_len();
      if (code_bytes == 0) return 1;
      if (code_bytes > 64) return 64;
      return code_bytes;
    endfunction

    function int unsigned eff_row();
      return (refs_row == 0) ? 1 : refs_row;
    endfunction

    function int pending();
      return counts_due.size();
    endfunction

    // store entry that the next reference byte reads has been loaded
    function bit next_ref_loaded();
      return loaded[(ref_pos >= eff_len()) ? 0 : ref_pos];
    endfunction

    function void set_reg(logic [pcpm_pkg::CFG_IDX_W-1:0] idx,
                          logic [pcpm_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        pcpm_pkg::REG_MODE:       mode = v[0];
        pcpm_pkg::REG_CODE_BYTES: code_bytes = v[6:0];
        pcpm_pkg::REG_REFS_ROW:   refs_row = v[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned ones(logic [7:0] v);
      int unsigned n;
      n = 0;
      for (int b = 0; b < 8; b++) n += v[b];
      return n;
    endfunction

    function void take_item(pcpm_pkg::in_item_t it);
      int unsigned len, row;
      logic [7:0]  comb;
      pcpm_pkg::out_item_t r;
      len = eff_len();
      row = eff_row();
      if (it.command == pcpm_pkg::CMD_LOAD) begin
        // load restarts the row
        if (load_pos >= len) load_pos = 0;
        query[load_pos]  = it.data;
        loaded[load_pos] = 1'b1;
        load_pos++;
        if (load_pos >= len) load_pos = 0;
        ref_pos = 0;
        acc     = 0;
        col     = 0;
        loads++;
      end else begin
        refs++;
        if (ref_pos >= len) ref_pos = 0;
        if (col >= row) col = 0;
        comb = (mode == pcpm_pkg::MODE_AND) ? (query[ref_pos] & it.data)
                                            : (query[ref_pos] ^ it.data);
        acc += ones(comb);
        if (acc > 1023) acc = 1023;
        ref_pos++;
        // last byte of a code gives a result
        if (ref_pos >= len) begin
          r.count   = acc[pcpm_pkg::COUNT_W-1:0];
          r.row_end = (col + 1 == row);
          counts_due.push_back(r);
          ref_pos = 0;
          acc     = 0;
          col     = r.row_end ? 0 : col + 1;
        end
      end
    endfunction

    function void check_result(pcpm_pkg::out_item_t got);
      pcpm_pkg::out_item_t want;
      if (counts_due.size() == 0) begin
        report($sformatf("result count=%0d row_end=%0d with none expected",
                         got.count, got.row_end));
        return;
      end
      want = counts_due.pop_front();
      results++;
      if (want.row_end) row_ends++;
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
      if (got.row_end !== want.row_end)
        report($sformatf("row_end %0d, expected %0d", got.row_end, want.row_end));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  pcpm_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  pcpm_pkg::out_item_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [pcpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pcpm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  popcount_predictor sb = new();

  int sent;
  int burst_left;
  int settings;
  bit gaps_on = 1'b1;
  bit hold_go = 1'b0;
  int hold_left, win, stall_pct;

  pairwise_code_popcount_matrix_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall windows, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_stall <= 1'b0;
      hold_left = 0;
      win       = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = 60;
      out_stall <= 1'b1;
    end else begin
      if (win == 0) begin
        win = 50;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      win = win - 1;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Offer one item, wait for it to be taken, then maybe pause
  task automatic send_item(input pcpm_pkg::cmd_t c, input logic [7:0] d);
    pcpm_pkg::in_item_t it;
    // never read a query byte that was not loaded
    if (c == pcpm_pkg::CMD_REF && !sb.next_ref_loaded()) c = pcpm_pkg::CMD_LOAD;
    it.command = c;
    it.data    = d;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_item(it);
    sent++;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Let everything drain, then the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcpm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[pcpm_pkg::CFG_DATA_W-1:0];
    sb.set_reg(idx, v[pcpm_pkg::CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic m, input int unsigned cb, input int unsigned rr);
    drain();
    write_reg(pcpm_pkg::REG_MODE, m);
    write_reg(pcpm_pkg::REG_CODE_BYTES, cb);
    write_reg(pcpm_pkg::REG_REFS_ROW, rr);
    settings++;
  endtask

  // Full query followed by a run of whole reference codes
  task automatic send_row();
    int unsigned len, k;
    len = sb.eff_len();
    for (int i = 0; i < len; i++) send_item(pcpm_pkg::CMD_LOAD, rand_byte());
    // long codes get a single reference per row
    k = (len > 16) ? 1 : $urandom_range(1, (sb.eff_row() < 4) ? sb.eff_row() + 1 : 4);
    for (int r = 0; r < k; r++)
      for (int i = 0; i < len; i++) send_item(pcpm_pkg::CMD_REF, rand_byte());
  endtask

  task automatic random_phase(input logic m, input int unsigned cb, input int unsigned rr,
                              input int quota, input bit squeeze);
    int start;
    apply_config(m, cb, rr);
    start = sent;
    // back-to-back references against a held-off receiver
    if (squeeze) begin
      gaps_on = 1'b0;
      hold_go = 1'b1;
      for (int i = 0; i < 30; i++) send_item(pcpm_pkg::CMD_REF, rand_byte());
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    while (sent - start < quota) begin
      if ($urandom_range(0, 99) < 80)
        send_row();
      else
        send_item(pcpm_pkg::cmd_t'($urandom_range(0, 1)), rand_byte());
    end
  endtask

  // Watchdog
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: Hamming mode, one-byte codes, one reference per row
    send_item(pcpm_pkg::CMD_LOAD, 8'h00);
    send_item(pcpm_pkg::CMD_REF,  8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'h00);
    send_item(pcpm_pkg::CMD_LOAD, 8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'h5A);

    // Intersection mode, two-byte codes, three per row; a load breaks a code
    apply_config(pcpm_pkg::MODE_AND, 2, 3);
    send_item(pcpm_pkg::CMD_LOAD, 8'hFF);
    send_item(pcpm_pkg::CMD_LOAD, 8'h0F);
    send_item(pcpm_pkg::CMD_REF,  8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'h00);
    send_item(pcpm_pkg::CMD_REF,  8'h00);
    send_item(pcpm_pkg::CMD_REF,  8'h81);
    send_item(pcpm_pkg::CMD_REF,  8'hFF);
    send_item(pcpm_pkg::CMD_REF,  8'hAA);
    send_item(pcpm_pkg::CMD_LOAD, 8'h55);
    send_item(pcpm_pkg::CMD_REF,  8'h3C);
    send_item(pcpm_pkg::CMD_REF,  8'hC3);
    send_item(pcpm_pkg::CMD_REF,  8'h7E);

    // Zero length and zero row act as one; the half-done code restarts
    apply_config(pcpm_pkg::MODE_XOR, 0, 0);
    send_item(pcpm_pkg::CMD_REF, 8'h00);
    send_item(pcpm_pkg::CMD_REF, 8'hFF);

    // Random phases, mostly short codes, one long code set
    random_phase(pcpm_pkg::MODE_XOR, 4,   3,     30, 1'b0);
    random_phase(pcpm_pkg::MODE_AND, 1,   1,     30, 1'b1);
    random_phase(pcpm_pkg::MODE_XOR, 3,   0,     30, 1'b0);
    random_phase(pcpm_pkg::MODE_AND, 2,   5,     30, 1'b0);
    random_phase(pcpm_pkg::MODE_XOR, 127, 65535, 60, 1'b0);
    random_phase(pcpm_pkg::MODE_XOR, 8,   2,     30, 1'b0);
    random_phase(pcpm_pkg::MODE_AND, 5,   4,     30, 1'b0);

    // Wait out the remaining results
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && sb.pending() > 0; n++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Ran %0d query loads and %0d reference bytes over %0d register settings,",
             sb.loads, sb.refs, settings + 1);
    $display("checking %0d counts (%0d at row end) in XOR and AND modes.",
             sb.results, sb.row_ends);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
